[sv/tdpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpa_pkg
// Shared types and codes of the transmit descriptor pair allocator.
// ----------------------------------------------------------------------------
package tdpa_pkg;

    // Descriptors taken by one packet: header plus data.
    localparam int PAIR_ENTRIES = 2;

    // Width of the available-ring running index.
    localparam int AVAIL_W = 16;

    // Request codes.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_OVERFREE = 2'd2;

    // Request sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SECOND,
        ST_FINISH
    } t_state;

endpackage

[sv/tdpa_link_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpa_link_mem
// Free-list link memory with a registered read port and per-entry valid
// bits, so that an entry never written reads as its reset link (i + 1).
// ----------------------------------------------------------------------------
module tdpa_link_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [AW-1:0] o_rd_data
);

    logic [AW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic          r_rd_valid;
    logic [AW-1:0] r_rd_addr;
    logic [AW-1:0] r_rd_data;
    logic [AW-1:0] w_reset_link;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // The last entry wraps back to entry zero.
    assign w_reset_link = (r_rd_addr == AW'(DEPTH - 1)) ? '0 : r_rd_addr + 1'b1;
    assign o_rd_data    = r_rd_valid ? r_rd_data : w_reset_link;

endmodule

[sv/tdpa_handle_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpa_handle_ram
// Buffer handle store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tdpa_handle_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/tx_descriptor_pair_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_descriptor_pair_allocator_unit
// A finished result passes the result slot, then the output register, and
// may wait in either while the output stalls. A new item enters as the last
// finishes; an allocate reads head, then data entry link via the one read port.
// Reset: synchronous, active low; the link memory is restored through valid
// bits at once, so no clearing pass runs and items are taken right after reset.
// ----------------------------------------------------------------------------
// Keeps a transmit descriptor table as a singly linked free list and hands out
// descriptor pairs. An allocate takes the first two free entries, stores the
// buffer handle at the data entry and reports the available-ring slot. A free
// links the pair back in at the head and returns the stored handle.
// ----------------------------------------------------------------------------
module tx_descriptor_pair_allocator_unit
    import tdpa_pkg::*;
#(
    parameter int QUEUE_SIZE   = 32,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic [HANDLE_WIDTH-1:0]         i_buffer_handle,
    input  logic [$clog2(QUEUE_SIZE)-1:0]   i_release_head,
    input  logic                            i_device_no_notify,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [$clog2(QUEUE_SIZE)-1:0]   o_head_index,
    output logic [$clog2(QUEUE_SIZE)-1:0]   o_data_index,
    output logic [$clog2(QUEUE_SIZE)-1:0]   o_ring_slot,
    output logic                            o_notify,
    output logic [HANDLE_WIDTH-1:0]         o_released_handle
);

    localparam int IDX_W = $clog2(QUEUE_SIZE);
    localparam int CNT_W = $clog2(QUEUE_SIZE + 1);

    // Sequencer and list state.
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_list_head;
    logic [CNT_W-1:0]     r_free_count;
    logic [AVAIL_W-1:0]   r_avail;
    logic [IDX_W-1:0]     r_slot;

    // The item in flight.
    logic                 r_act;
    logic                 r_ok;
    logic                 r_relink;
    logic                 r_no_notify;
    logic [IDX_W-1:0]     r_rel;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_data;
    logic [IDX_W-1:0]     r_slot_cap;
    logic [HANDLE_WIDTH-1:0] r_handle;

    // Finished result waiting for the output register.
    logic                 r_res_valid;
    logic [1:0]           r_res_status;
    logic [IDX_W-1:0]     r_res_head;
    logic [IDX_W-1:0]     r_res_data;
    logic [IDX_W-1:0]     r_res_slot;
    logic                 r_res_notify;
    logic [HANDLE_WIDTH-1:0] r_res_handle;

    // Output register.
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [IDX_W-1:0]     r_out_head;
    logic [IDX_W-1:0]     r_out_data;
    logic [IDX_W-1:0]     r_out_slot;
    logic                 r_out_notify;
    logic [HANDLE_WIDTH-1:0] r_out_handle;

    // Memory ports.
    logic                 w_link_wr_en, w_link_rd_en;
    logic [IDX_W-1:0]     w_link_rd_addr;
    logic [IDX_W-1:0]     w_link_rd;
    logic                 w_hnd_wr_en, w_hnd_rd_en;
    logic [HANDLE_WIDTH-1:0] w_hnd_rd;

    logic                 w_res_move;
    logic                 w_fin_done;
    logic                 w_in_accept;
    logic                 w_ok;
    logic [IDX_W-1:0]     w_head_fwd;
    logic [IDX_W-1:0]     w_rel_mod;

    // A result moves on whenever the output register is empty or being taken.
    assign w_res_move = r_res_valid && (!r_out_valid || !i_out_stall);

    // The item in its last cycle completes once the result slot is free.
    assign w_fin_done = (r_state == ST_FINISH) && (!r_res_valid || w_res_move);

    // A new item may enter while the previous one completes.
    assign o_in_stall  = !((r_state == ST_IDLE) || w_fin_done);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // When an allocate completes in this cycle its new list head is only on
    // the link read data; forward it to the entering item.
    assign w_head_fwd = (w_fin_done && (r_act == ACT_ALLOC) && r_ok) ? w_link_rd
                                                                    : r_list_head;

    // Release index reduced into the table range (a single compare is enough
    // since the port cannot reach twice the table size).
    assign w_rel_mod = ({1'b0, i_release_head} >= (IDX_W + 1)'(QUEUE_SIZE))
                     ? IDX_W'({1'b0, i_release_head} - (IDX_W + 1)'(QUEUE_SIZE))
                     : i_release_head;

    // An allocate needs a whole pair free; a free must leave room for a pair.
    assign w_ok = (i_action == ACT_ALLOC)
                ? (r_free_count >= CNT_W'(PAIR_ENTRIES))
                : (r_free_count <= CNT_W'(QUEUE_SIZE - PAIR_ENTRIES));

    // Link memory: the first read is issued as the item enters (head entry on
    // allocate, released head on free); an allocate reads the data entry's
    // link in state ST_SECOND, and a free relinks the data entry there.
    assign w_link_rd_en   = w_in_accept ||
                            ((r_state == ST_SECOND) && (r_act == ACT_ALLOC) && r_ok);
    assign w_link_rd_addr = w_in_accept ? ((i_action == ACT_ALLOC) ? w_head_fwd : w_rel_mod)
                                        : w_link_rd;
    assign w_link_wr_en   = (r_state == ST_SECOND) && (r_act == ACT_FREE) && r_ok && r_relink;

    // Handle store: written at the data entry on allocate, read there on free.
    assign w_hnd_wr_en = (r_state == ST_SECOND) && (r_act == ACT_ALLOC) && r_ok;
    assign w_hnd_rd_en = (r_state == ST_SECOND) && (r_act == ACT_FREE) && r_ok;

    tdpa_link_mem #(
        .DEPTH (QUEUE_SIZE),
        .AW    (IDX_W)
    ) u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_link_wr_en),
        .i_wr_addr (w_link_rd),
        .i_wr_data (r_list_head),
        .i_rd_en   (w_link_rd_en),
        .i_rd_addr (w_link_rd_addr),
        .o_rd_data (w_link_rd)
    );

    tdpa_handle_ram #(
        .DEPTH (QUEUE_SIZE),
        .AW    (IDX_W),
        .DW    (HANDLE_WIDTH)
    ) u_handle_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_hnd_wr_en),
        .i_wr_addr (w_link_rd),
        .i_wr_data (r_handle),
        .i_rd_en   (w_hnd_rd_en),
        .i_rd_addr (w_link_rd),
        .o_rd_data (w_hnd_rd)
    );

    // Sequencer: enter, second link access, finish.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_SECOND;
                end
            end
            ST_SECOND: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_fin_done) begin
                    n_state = w_in_accept ? ST_SECOND : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // List state. The pool count and ring index move as the item enters, so
    // the next item is checked against them at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head  <= '0;
            r_free_count <= CNT_W'(QUEUE_SIZE);
            r_avail      <= '0;
            r_slot       <= '0;
        end else begin
            if (w_in_accept && w_ok) begin
                if (i_action == ACT_ALLOC) begin
                    r_free_count <= r_free_count - CNT_W'(PAIR_ENTRIES);
                    r_avail      <= r_avail + 1'b1;
                    // The slot follows the ring index modulo the table size,
                    // restarting when the ring index wraps.
                    if ((r_avail == {AVAIL_W{1'b1}}) ||
                        (r_slot == IDX_W'(QUEUE_SIZE - 1))) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end else begin
                    r_free_count <= r_free_count + CNT_W'(PAIR_ENTRIES);
                end
            end
            // A free takes the head after its relink has used the old head.
            if ((r_state == ST_SECOND) && (r_act == ACT_FREE) && r_ok) begin
                r_list_head <= r_rel;
            end
            // An allocate takes the link of its data entry as the new head.
            if (w_fin_done && (r_act == ACT_ALLOC) && r_ok) begin
                r_list_head <= w_link_rd;
            end
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_act       <= i_action;
            r_ok        <= w_ok;
            r_relink    <= (r_free_count != '0);
            r_no_notify <= i_device_no_notify;
            r_rel       <= w_rel_mod;
            r_head      <= w_head_fwd;
            r_slot_cap  <= r_slot;
            r_handle    <= i_buffer_handle;
        end
        if (r_state == ST_SECOND) begin
            r_data <= w_link_rd;
        end
    end

    // Result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_fin_done) begin
            r_res_valid <= 1'b1;
        end else if (w_res_move) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_done) begin
            r_res_status <= STAT_OK;
            r_res_head   <= '0;
            r_res_data   <= '0;
            r_res_slot   <= '0;
            r_res_notify <= 1'b0;
            r_res_handle <= '0;
            if (!r_ok) begin
                r_res_status <= (r_act == ACT_ALLOC) ? STAT_FULL : STAT_OVERFREE;
            end else if (r_act == ACT_ALLOC) begin
                r_res_head   <= r_head;
                r_res_data   <= r_data;
                r_res_slot   <= r_slot_cap;
                r_res_notify <= !r_no_notify;
            end else begin
                r_res_head   <= r_rel;
                r_res_data   <= r_data;
                r_res_handle <= w_hnd_rd;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_move) begin
            r_out_status <= r_res_status;
            r_out_head   <= r_res_head;
            r_out_data   <= r_res_data;
            r_out_slot   <= r_res_slot;
            r_out_notify <= r_res_notify;
            r_out_handle <= r_res_handle;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_head_index      = r_out_head;
    assign o_data_index      = r_out_data;
    assign o_ring_slot       = r_out_slot;
    assign o_notify          = r_out_notify;
    assign o_released_handle = r_out_handle;

    // An item that enters always goes to its second memory access next.
    a_accept_to_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ST_SECOND))
        else $error("accepted item did not reach its second cycle");

    // A finished item waits rather than overwrite a pending result.
    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && r_res_valid && !w_res_move) |=> (r_state == ST_FINISH))
        else $error("finished item left while the result slot was busy");

    // A granted allocate takes exactly one pair from the pool.
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_action == ACT_ALLOC) && w_ok)
        |=> (r_free_count == $past(r_free_count) - CNT_W'(PAIR_ENTRIES)))
        else $error("allocate did not take one pair from the pool");

    // The pool never holds more entries than the table (checked in ST_SECOND).
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SECOND) |-> (r_free_count <= CNT_W'(QUEUE_SIZE)))
        else $error("free count above table size");

    // Output becomes valid only from a pending result.
    a_out_from_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_res_valid))
        else $error("output valid without a pending result");

endmodule
